@@ sv/pva_pkg.sv @@
// Shared types, constants and helpers for the polyphonic voice allocator.
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int NOTE_W     = 7;
  localparam int VEL_IN_W   = 12;
  localparam int VEL_W      = 11;
  localparam int SLOT_OUT_W = 5;
  localparam int COUNT_W    = 6;
  localparam int LIMIT_W    = 6;

  // Defaults and limits
  localparam int                 VOICE_SLOTS_DEF = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 6'd32;
  localparam logic [VEL_W-1:0]   VEL_ONE         = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 6'd63;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_ALL_OFF  = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming transaction, reset the scan
    logic scan;   // read one slot and advance the scan index
    logic apply;  // update the table and register the result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index sits on the last configured slot
  } dp_status_t;

  // Saturate a signed Q1.10 velocity into 0..1.0
  function automatic logic [VEL_W-1:0] clamp_velocity(input logic signed [VEL_IN_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({1'b0, VEL_ONE})) begin
      return VEL_ONE;
    end else begin
      return v[VEL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/pva_ctrl.sv @@
// Sequencing state machine of the polyphonic voice allocator.
`timescale 1ns / 1ps
`default_nettype none

module pva_ctrl
  import pva_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] cmd_i,
  input  wire dp_status_t       status_i,
  output logic                  busy,
  output ctrl_cmd_t             ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_APPLY = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   take;
  logic   needs_scan;

  // A transaction is taken when idle and started
  assign busy       = (state_q != ST_IDLE);
  assign take       = start && !busy;
  assign needs_scan = (cmd_e'(cmd_i) == CMD_NOTE_ON) || (cmd_e'(cmd_i) == CMD_NOTE_OFF);

  // Next state and datapath commands
  always_comb begin
    state_d      = state_q;
    ctrl_o.load  = 1'b0;
    ctrl_o.scan  = 1'b0;
    ctrl_o.apply = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          ctrl_o.load = 1'b1;
          state_d     = needs_scan ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // last slot read is being compared
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        ctrl_o.apply = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/pva_datapath.sv @@
// Voice table, slot scan and result registers of the polyphonic voice allocator.
`timescale 1ns / 1ps
`default_nettype none

module pva_datapath
  import pva_pkg::*;
#(
  parameter int VOICE_SLOTS = VOICE_SLOTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ctrl_cmd_t                  ctrl_i,
  output dp_status_t                      status_o,
  input  wire logic [CMD_W-1:0]           cmd_i,
  input  wire logic [NOTE_W-1:0]          note_number_i,
  input  wire logic signed [VEL_IN_W-1:0] velocity_in_i,
  input  wire logic                       voice_limit_we_i,
  input  wire logic [LIMIT_W-1:0]         voice_limit_i,
  output logic                            done_o,
  output logic                            accepted_o,
  output logic [SLOT_OUT_W-1:0]           voice_slot_o,
  output logic [VEL_W-1:0]                voice_velocity_o,
  output logic [COUNT_W-1:0]              active_total_o
);

  localparam int IDX_W  = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int WIDE_W = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;

  // Last usable slot index for a written voice limit
  function automatic logic [IDX_W-1:0] last_index(input logic [LIMIT_W-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(v);
    if (v == '0) begin
      return '0;
    end else if (32'(v) > 32'(VOICE_SLOTS)) begin
      return IDX_W'(VOICE_SLOTS - 1);
    end else begin
      return IDX_W'(wide - 1'b1);
    end
  endfunction

  // Slot storage: note and velocity in memory, marks in flops
  logic [NOTE_W-1:0]      note_mem [VOICE_SLOTS];
  logic [VEL_W-1:0]       vel_mem  [VOICE_SLOTS];
  logic [VOICE_SLOTS-1:0] active_q;
  logic [VOICE_SLOTS-1:0] releasing_q;
  logic [COUNT_W-1:0]     count_q;
  logic [IDX_W-1:0]       limit_last_q;

  // Captured transaction
  cmd_e              cmd_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;

  // Scan pipeline
  logic [IDX_W-1:0]  scan_idx_q;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              rd_active_q;
  logic [NOTE_W-1:0] rd_note_q;
  logic [VEL_W-1:0]  rd_vel_q;

  // Search results
  logic              match_found_q;
  logic [IDX_W-1:0]  match_idx_q;
  logic [VEL_W-1:0]  match_vel_q;
  logic              free_found_q;
  logic [IDX_W-1:0]  free_idx_q;

  // Result registers
  logic                  done_q;
  logic                  accepted_q;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic [VEL_W-1:0]      vel_out_q;

  logic             on_hit;
  logic [IDX_W-1:0] tgt_idx;
  logic             write_slot;

  assign status_o.scan_last = (scan_idx_q == limit_last_q);

  // Same-note slot wins over a free one
  assign on_hit     = match_found_q || free_found_q;
  assign tgt_idx    = match_found_q ? match_idx_q : free_idx_q;
  assign write_slot = ctrl_i.apply && (cmd_q == CMD_NOTE_ON) && on_hit;

  // Memory read during the scan, write on an accepted note-on
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan) begin
      rd_note_q   <= note_mem[scan_idx_q];
      rd_vel_q    <= vel_mem[scan_idx_q];
      rd_active_q <= active_q[scan_idx_q];
      rd_idx_q    <= scan_idx_q;
    end
    if (write_slot) begin
      note_mem[tgt_idx] <= note_q;
      vel_mem[tgt_idx]  <= vel_q;
    end
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_e'(cmd_i);
      note_q <= note_number_i;
      vel_q  <= clamp_velocity(velocity_in_i);
    end
  end

  // Marks, count, scan control and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= '0;
      releasing_q   <= '0;
      count_q       <= '0;
      limit_last_q  <= last_index(LIMIT_RESET);
      scan_idx_q    <= '0;
      rd_valid_q    <= 1'b0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      match_vel_q   <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      done_q        <= 1'b0;
      accepted_q    <= 1'b0;
      slot_q        <= '0;
      vel_out_q     <= '0;
    end else begin
      done_q     <= 1'b0;
      rd_valid_q <= ctrl_i.scan;

      // limit write clears the table
      if (voice_limit_we_i) begin
        limit_last_q <= last_index(voice_limit_i);
        active_q     <= '0;
        releasing_q  <= '0;
        count_q      <= '0;
      end

      if (ctrl_i.load) begin
        scan_idx_q    <= '0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else if (ctrl_i.scan) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end

      // keep the lowest matching and lowest free slot
      if (rd_valid_q) begin
        if (rd_active_q && (rd_note_q == note_q) && !match_found_q) begin
          match_found_q <= 1'b1;
          match_idx_q   <= rd_idx_q;
          match_vel_q   <= rd_vel_q;
        end
        if (!rd_active_q && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= rd_idx_q;
        end
      end

      if (ctrl_i.apply) begin
        done_q     <= 1'b1;
        accepted_q <= 1'b0;
        slot_q     <= '0;
        vel_out_q  <= '0;
        case (cmd_q)
          CMD_NOTE_ON: begin
            if (on_hit) begin
              accepted_q <= 1'b1;
              slot_q     <= SLOT_OUT_W'(tgt_idx);
              vel_out_q  <= vel_q;
              if (!match_found_q) begin
                active_q[tgt_idx]    <= 1'b1;
                releasing_q[tgt_idx] <= 1'b0;
                if (count_q != COUNT_MAX) begin
                  count_q <= count_q + 1'b1;
                end
              end
            end
          end
          CMD_NOTE_OFF: begin
            if (match_found_q) begin
              accepted_q               <= 1'b1;
              slot_q                   <= SLOT_OUT_W'(match_idx_q);
              vel_out_q                <= match_vel_q;
              active_q[match_idx_q]    <= 1'b0;
              releasing_q[match_idx_q] <= 1'b1;
              if (count_q != '0) begin
                count_q <= count_q - 1'b1;
              end
            end
          end
          CMD_ALL_OFF: begin
            accepted_q  <= 1'b1;
            active_q    <= '0;
            releasing_q <= '0;
            count_q     <= '0;
          end
          default: begin
            accepted_q <= 1'b0;
          end
        endcase
      end
    end
  end

  assign done_o           = done_q;
  assign accepted_o       = accepted_q;
  assign voice_slot_o     = slot_q;
  assign voice_velocity_o = vel_out_q;
  assign active_total_o   = count_q;

  // Count tracks the active marks while it cannot saturate
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (VOICE_SLOTS > 63) || (32'(count_q) == $countones(active_q)))
    else $error("active count disagrees with active marks");

  // A slot is never both playing and releasing
  a_marks_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & releasing_q) == '0)
    else $error("slot both active and releasing");

  // Result strobe lasts a single cycle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  // Rejected transactions report slot and velocity zero
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !accepted_q) |-> ((slot_q == '0) && (vel_out_q == '0)))
    else $error("rejected result carries slot data");

  // Slots found for the transaction being applied lie inside the configured voices
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.apply |->
      ((!free_found_q || (free_idx_q <= limit_last_q)) &&
       (!match_found_q || (match_idx_q <= limit_last_q))))
    else $error("slot found beyond voice limit");

endmodule

`default_nettype wire

@@ sv/polyphonic_voice_allocator.sv @@
// Top level of the polyphonic voice allocator: controller plus voice table datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Commands enter on cmd_i / note_number_i / velocity_in_i and are taken at a
//   rising edge with start high and busy low. Each command yields exactly one
//   result, shown for one cycle with done_o high: accepted_o, voice_slot_o,
//   voice_velocity_o and active_total_o. The receiver cannot stall the block.
//   Write the voice limit via voice_limit_we_i / voice_limit_i only while idle;
//   the block itself does not enforce this. A write clears every voice and the active count.
// Sequencing:
//   Note-on and note-off walk the slot table one slot per clock through the
//   note/velocity memory read port over the configured voice count
//   (1..VOICE_SLOTS), wait in ST_WAIT while the last slot read is compared,
//   then apply; done_o is registered from the apply state. All-notes-off and
//   the unused command skip the scan and go straight to the apply state. busy
//   is low again in the done_o cycle, so the next transaction may start there.
// Reset:
//   rst_ni clears all voice marks and the count and sets the limit to 32
//   (capped at VOICE_SLOTS). No clearing pass is needed.
module polyphonic_voice_allocator
  import pva_pkg::*;
#(
  parameter int VOICE_SLOTS = VOICE_SLOTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [CMD_W-1:0]           cmd_i,
  input  wire logic [NOTE_W-1:0]          note_number_i,
  input  wire logic signed [VEL_IN_W-1:0] velocity_in_i,
  input  wire logic                       voice_limit_we_i,
  input  wire logic [LIMIT_W-1:0]         voice_limit_i,
  output logic                            done_o,
  output logic                            accepted_o,
  output logic [SLOT_OUT_W-1:0]           voice_slot_o,
  output logic [VEL_W-1:0]                voice_velocity_o,
  output logic [COUNT_W-1:0]              active_total_o
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  pva_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .status_i (status),
    .busy     (busy),
    .ctrl_o   (ctrl)
  );

  pva_datapath #(
    .VOICE_SLOTS (VOICE_SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .cmd_i            (cmd_i),
    .note_number_i    (note_number_i),
    .velocity_in_i    (velocity_in_i),
    .voice_limit_we_i (voice_limit_we_i),
    .voice_limit_i    (voice_limit_i),
    .done_o           (done_o),
    .accepted_o       (accepted_o),
    .voice_slot_o     (voice_slot_o),
    .voice_velocity_o (voice_velocity_o),
    .active_total_o   (active_total_o)
  );

endmodule

`default_nettype wire
